>>> rtl/core/rcmp_pkg.sv
// Shared types and constants of the real/complex matrix product block.
// Transaction payloads, pipeline control word and register map.
// No dependencies.
package rcmp_pkg;

   localparam int KIND_W     = 2;
   localparam int IDX_W      = 3;
   localparam int VAL_W      = 16;
   localparam int PROD_W     = 2 * VAL_W;
   localparam int ACC_W      = 40;
   localparam int CNT_W      = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_LOAD_REAL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_CPLX = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START     = 2'd2;

   localparam logic [1:0] REG_ORDER     = 2'd0;
   localparam logic [1:0] REG_DIMENSION = 2'd1;
   localparam logic [1:0] REG_CUTOFF    = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [VAL_W-1:0] value_re;
      logic signed [VAL_W-1:0] value_im;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic signed [ACC_W-1:0] product_re;
      logic signed [ACC_W-1:0] product_im;
      logic                    last;
   } rsp_type;

   // one multiply-accumulate step travelling down the pipeline
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             term;
      logic             done;
      logic             last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } ctrl_type;

endpackage

>>> rtl/core/rcmp_mem.sv
// Real and complex element stores, one write and one registered read port each.
// Depends on rcmp_pkg.
module rcmp_mem #(
   parameter int MAX_DIM = 8,
   parameter int AW      = 6
) (
   input  logic                             clock,
   input  logic                             wr_real,
   input  logic                             wr_cplx,
   input  logic [AW-1:0]                    wr_addr,
   input  logic signed [rcmp_pkg::VAL_W-1:0] wr_re,
   input  logic signed [rcmp_pkg::VAL_W-1:0] wr_im,
   input  logic                             rd_en,
   input  logic [AW-1:0]                    rd_addr_real,
   input  logic [AW-1:0]                    rd_addr_cplx,
   output logic signed [rcmp_pkg::VAL_W-1:0] rd_real,
   output logic signed [rcmp_pkg::VAL_W-1:0] rd_cre,
   output logic signed [rcmp_pkg::VAL_W-1:0] rd_cim
);
   import rcmp_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;

   logic [VAL_W-1:0]   real_mem [DEPTH];
   logic [2*VAL_W-1:0] cplx_mem [DEPTH];
   logic [2*VAL_W-1:0] cplx_rd;

   always_ff @(posedge clock) begin
      if (wr_real) begin
         real_mem[wr_addr] <= wr_re;
      end
      if (wr_cplx) begin
         cplx_mem[wr_addr] <= {wr_re, wr_im};
      end
      if (rd_en) begin
         rd_real <= real_mem[rd_addr_real];
         cplx_rd <= cplx_mem[rd_addr_cplx];
      end
   end

   assign rd_cre = cplx_rd[2*VAL_W-1:VAL_W];
   assign rd_cim = cplx_rd[VAL_W-1:0];

endmodule

>>> rtl/core/rcmp_seq.sv
// Index sequencer: walks row, column and shared index, drives store read addresses.
// Depends on rcmp_pkg.
module rcmp_seq #(
   parameter int MAX_DIM = 8,
   parameter int AW      = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       start,
   input  logic                       order,
   input  logic [rcmp_pkg::CNT_W-1:0] dimension,
   input  logic [rcmp_pkg::CNT_W-1:0] cutoff,
   output logic                       busy,
   output rcmp_pkg::ctrl_type         ctrl,
   output logic [AW-1:0]              rd_addr_real,
   output logic [AW-1:0]              rd_addr_cplx
);
   import rcmp_pkg::*;

   localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_DIM);
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic             state_ff, state_in;
   logic [IW-1:0]    i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CNT_W-1:0] n_ff, n_in, c_ff, c_in;
   logic [CNT_W-1:0] n_sat, c_sat;
   logic             skip, k_end, j_end, i_end;

   always_comb begin
      n_sat = (dimension > MAX_N) ? MAX_N : dimension;
      c_sat = (cutoff > n_sat) ? n_sat : cutoff;
      skip  = (c_ff == '0) || (order && (CNT_W'(i_ff) >= c_ff));
      k_end = skip || (CNT_W'(k_ff) == c_ff - 1'b1);
      j_end = CNT_W'(j_ff) == n_ff - 1'b1;
      i_end = CNT_W'(i_ff) == n_ff - 1'b1;

      ctrl.valid = (state_ff == ST_RUN);
      ctrl.first = (k_ff == '0);
      ctrl.term  = !skip;
      ctrl.done  = k_end;
      ctrl.last  = k_end && j_end && i_end;
      ctrl.row   = IDX_W'(i_ff);
      ctrl.col   = IDX_W'(j_ff);

      if (order) begin
         rd_addr_real = AW'(k_ff * MAX_DIM + j_ff);
         rd_addr_cplx = AW'(i_ff * MAX_DIM + k_ff);
      end else begin
         rd_addr_real = AW'(i_ff * MAX_DIM + k_ff);
         rd_addr_cplx = AW'(k_ff * MAX_DIM + j_ff);
      end

      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      c_in     = c_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (n_sat != '0)) begin
               state_in = ST_RUN;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               n_in     = n_sat;
               c_in     = c_sat;
            end
         end
         ST_RUN: begin
            if (adv) begin
               if (!k_end) begin
                  k_in = k_ff + 1'b1;
               end else begin
                  k_in = '0;
                  if (!j_end) begin
                     j_in = j_ff + 1'b1;
                  end else begin
                     j_in = '0;
                     if (i_end) begin
                        state_in = ST_IDLE;
                     end else begin
                        i_in = i_ff + 1'b1;
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      n_ff <= n_in;
      c_ff <= c_in;
   end

   assign busy = (state_ff == ST_RUN);

endmodule

>>> rtl/core/rcmp_mac.sv
// Multiply-accumulate pipeline and result register with stall handling.
// Depends on rcmp_pkg.
module rcmp_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  rcmp_pkg::ctrl_type                ctrl,
   input  logic signed [rcmp_pkg::VAL_W-1:0] rd_real,
   input  logic signed [rcmp_pkg::VAL_W-1:0] rd_cre,
   input  logic signed [rcmp_pkg::VAL_W-1:0] rd_cim,
   input  logic                              rsp_stall,
   output logic                              adv,
   output logic                              rsp_valid,
   output rcmp_pkg::rsp_type                 rsp_data
);
   import rcmp_pkg::*;

   ctrl_type                ctrl1_ff, ctrl2_ff;
   logic signed [PROD_W-1:0] prod_re_ff, prod_re_in, prod_im_ff, prod_im_in;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic [ACC_W-1:0]         base_re, base_im, add_re, add_im;

   always_comb begin
      adv        = !(rsp_valid_ff && rsp_stall);
      prod_re_in = rd_real * rd_cre;
      prod_im_in = rd_real * rd_cim;

      base_re = ctrl2_ff.first ? '0 : acc_re_ff;
      base_im = ctrl2_ff.first ? '0 : acc_im_ff;
      add_re  = ctrl2_ff.term ? {{(ACC_W-PROD_W){prod_re_ff[PROD_W-1]}}, prod_re_ff} : '0;
      add_im  = ctrl2_ff.term ? {{(ACC_W-PROD_W){prod_im_ff[PROD_W-1]}}, prod_im_ff} : '0;
      acc_re_in = base_re + add_re;
      acc_im_in = base_im + add_im;

      rsp_data_in.out_row    = ctrl2_ff.row;
      rsp_data_in.out_col    = ctrl2_ff.col;
      rsp_data_in.product_re = acc_re_in;
      rsp_data_in.product_im = acc_im_in;
      rsp_data_in.last       = ctrl2_ff.last;

      rsp_valid_in = adv ? (ctrl2_ff.valid && ctrl2_ff.done) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff     <= '0;
         ctrl2_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            ctrl1_ff <= ctrl;
            ctrl2_ff <= ctrl1_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv) begin
         prod_re_ff <= prod_re_in;
         prod_im_ff <= prod_im_in;
         if (ctrl2_ff.valid) begin
            acc_re_ff <= acc_re_in;
            acc_im_ff <= acc_im_in;
            if (ctrl2_ff.done) begin
               rsp_data_ff <= rsp_data_in;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/real_complex_matrix_product.sv
// Top level of the real/complex matrix product: register port, stores, sequencer, MAC.
// Depends on rcmp_pkg, rcmp_mem, rcmp_seq and rcmp_mac.
//
// A load transaction writes one element of the real or complex store. A start
// transaction holds the input for min(dimension, MAX_DIM) squared element slots;
// each slot sums cutoff terms, or none for a row emitted as zero, as the single MAC
// unit reads one term per cycle from the store read ports while no result stalls.
// Results pass the store read, product and result registers and leave in row-major
// order; a stalled result holds the whole pipeline. The stores have no reset.
module real_complex_matrix_product #(
   parameter int MAX_DIM = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rcmp_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rcmp_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rcmp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [rcmp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [rcmp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import rcmp_pkg::*;

   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
   localparam logic [CNT_W-1:0] DIM_RESET = CNT_W'(MAX_DIM);

   logic             order_ff, order_in;
   logic [CNT_W-1:0] dimension_ff, dimension_in, cutoff_ff, cutoff_in;
   logic             csr_wr, req_acc, in_range, wr_real, wr_cplx, start, busy, adv;
   logic [AW-1:0]    wr_addr, rd_addr_real, rd_addr_cplx;
   logic signed [VAL_W-1:0] rd_real, rd_cre, rd_cim;
   ctrl_type         ctrl;

   always_comb begin
      csr_pready = 1'b1;
      csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
      order_in     = order_ff;
      dimension_in = dimension_ff;
      cutoff_in    = cutoff_ff;
      csr_prdata   = '0;
      unique case (csr_paddr[3:2])
         REG_ORDER: begin
            csr_prdata = CSR_DATA_W'(order_ff);
            if (csr_wr) order_in = csr_pwdata[0];
         end
         REG_DIMENSION: begin
            csr_prdata = CSR_DATA_W'(dimension_ff);
            if (csr_wr) dimension_in = csr_pwdata[CNT_W-1:0];
         end
         REG_CUTOFF: begin
            csr_prdata = CSR_DATA_W'(cutoff_ff);
            if (csr_wr) cutoff_in = csr_pwdata[CNT_W-1:0];
         end
         default: csr_prdata = '0;
      endcase

      req_stall = busy;
      req_acc   = req_valid && !req_stall;
      in_range  = (32'(req_data.row) < MAX_DIM) && (32'(req_data.col) < MAX_DIM);
      wr_real   = req_acc && in_range && (req_data.kind == KIND_LOAD_REAL);
      wr_cplx   = req_acc && in_range && (req_data.kind == KIND_LOAD_CPLX);
      start     = req_acc && (req_data.kind == KIND_START);
      wr_addr   = AW'(req_data.row * MAX_DIM + req_data.col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff     <= 1'b0;
         dimension_ff <= DIM_RESET;
         cutoff_ff    <= DIM_RESET;
      end else begin
         order_ff     <= order_in;
         dimension_ff <= dimension_in;
         cutoff_ff    <= cutoff_in;
      end
   end

   rcmp_mem #(
      .MAX_DIM (MAX_DIM),
      .AW      (AW)
   ) u_mem (
      .clock        (clock),
      .wr_real      (wr_real),
      .wr_cplx      (wr_cplx),
      .wr_addr      (wr_addr),
      .wr_re        (req_data.value_re),
      .wr_im        (req_data.value_im),
      .rd_en        (adv),
      .rd_addr_real (rd_addr_real),
      .rd_addr_cplx (rd_addr_cplx),
      .rd_real      (rd_real),
      .rd_cre       (rd_cre),
      .rd_cim       (rd_cim)
   );

   rcmp_seq #(
      .MAX_DIM (MAX_DIM),
      .AW      (AW)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .start        (start),
      .order        (order_ff),
      .dimension    (dimension_ff),
      .cutoff       (cutoff_ff),
      .busy         (busy),
      .ctrl         (ctrl),
      .rd_addr_real (rd_addr_real),
      .rd_addr_cplx (rd_addr_cplx)
   );

   rcmp_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .rd_real   (rd_real),
      .rd_cre    (rd_cre),
      .rd_cim    (rd_cim),
      .rsp_stall (rsp_stall),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> verif/real_complex_matrix_product_tb.sv
// Self-checking testbench of real_complex_matrix_product: loads both stores, runs products
// under several order/dimension/cutoff settings and checks every element emitted.
// Depends on rcmp_pkg and the real_complex_matrix_product RTL.
module real_complex_matrix_product_tb;
   import rcmp_pkg::*;

   localparam int MAX_DIM = 8;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   class product_scoreboard;
      logic signed [VAL_W-1:0] real_elem [MAX_DIM*MAX_DIM];
      logic signed [VAL_W-1:0] cplx_re [MAX_DIM*MAX_DIM];
      logic signed [VAL_W-1:0] cplx_im [MAX_DIM*MAX_DIM];
      bit                      order;
      bit [CNT_W-1:0]          dim;
      bit [CNT_W-1:0]          cut;
      rsp_type                 expected_elements [$];
      int                      errors;

      function new();
         order  = 1'b0;
         dim    = CNT_W'(MAX_DIM);
         cut    = CNT_W'(MAX_DIM);
         errors = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_ORDER:     order = value[0];
            REG_DIMENSION: dim = value[CNT_W-1:0];
            REG_CUTOFF:    cut = value[CNT_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_elements.size();
      endfunction

      function void queue_product();
         int      n, c, i, j, k, ra, ca;
         longint  sum_re, sum_im, weight;
         rsp_type element;
         n = (dim > MAX_DIM) ? MAX_DIM : int'(dim);
         c = (cut > n) ? n : int'(cut);
         for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++) begin
               sum_re = 0;
               sum_im = 0;
               // complex x real: rows past the cutoff come out as zero
               if (!(order && i >= c)) begin
                  for (k = 0; k < c; k++) begin
                     ra = order ? k * MAX_DIM + j : i * MAX_DIM + k;
                     ca = order ? i * MAX_DIM + k : k * MAX_DIM + j;
                     weight = longint'(real_elem[ra]);
                     sum_re += weight * longint'(cplx_re[ca]);
                     sum_im += weight * longint'(cplx_im[ca]);
                  end
               end
               element.out_row    = i[IDX_W-1:0];
               element.out_col    = j[IDX_W-1:0];
               element.product_re = sum_re[ACC_W-1:0];
               element.product_im = sum_im[ACC_W-1:0];
               element.last       = (i == n - 1) && (j == n - 1);
               expected_elements.push_back(element);
            end
         end
      endfunction

      function void record_request(req_type item);
         int addr;
         addr = int'({item.row, item.col});
         case (item.kind)
            KIND_LOAD_REAL: real_elem[addr] = item.value_re;
            KIND_LOAD_CPLX: begin
               cplx_re[addr] = item.value_re;
               cplx_im[addr] = item.value_im;
            end
            KIND_START: queue_product();
            default: ;
         endcase
      endfunction

      function void check_element(rsp_type got);
         rsp_type want;
         if (expected_elements.size() == 0) begin
            $error("unexpected product element row %0d col %0d", got.out_row, got.out_col);
            errors++;
            return;
         end
         want = expected_elements.pop_front();
         if (got.out_row !== want.out_row) begin
            $error("out_row expected %0d actual %0d", want.out_row, got.out_row);
            errors++;
         end
         if (got.out_col !== want.out_col) begin
            $error("out_col expected %0d actual %0d", want.out_col, got.out_col);
            errors++;
         end
         if (got.product_re !== want.product_re) begin
            $error("product_re expected %0d actual %0d", want.product_re, got.product_re);
            errors++;
         end
         if (got.product_im !== want.product_im) begin
            $error("product_im expected %0d actual %0d", want.product_im, got.product_im);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   product_scoreboard board;
   int                idle_pct = 0;
   bit                long_hold_pending = 1'b0;
   bit [63:0]         real_written = '0;
   bit [63:0]         cplx_written = '0;
   bit                cur_order;
   int                cur_dim;
   int                cur_cut;

   real_complex_matrix_product #(.MAX_DIM(MAX_DIM)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transaction monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.record_request(req_data);
         if (rsp_valid && !rsp_stall) board.check_element(rsp_data);
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin : receiver
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (500) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      #50_000_000;
      $display("real_complex_matrix_product_tb failed");
      $finish;
   end

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 11))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   task automatic send_item(input req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic sender_gap();
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic send_load(input logic [KIND_W-1:0] kind, input int row, input int col,
                            input logic [VAL_W-1:0] re, input logic [VAL_W-1:0] im);
      req_type item;
      item.kind     = kind;
      item.row      = row[IDX_W-1:0];
      item.col      = col[IDX_W-1:0];
      item.value_re = re;
      item.value_im = im;
      if (kind == KIND_LOAD_REAL) real_written[row * MAX_DIM + col] = 1'b1;
      if (kind == KIND_LOAD_CPLX) cplx_written[row * MAX_DIM + col] = 1'b1;
      send_item(item);
   endtask

   task automatic send_other(input logic [KIND_W-1:0] kind);
      req_type item;
      item.kind     = kind;
      item.row      = IDX_W'($urandom);
      item.col      = IDX_W'($urandom);
      item.value_re = rand_value();
      item.value_im = rand_value();
      send_item(item);
   endtask

   task automatic fill_store(input logic [KIND_W-1:0] kind, input int rows, input int cols,
                             inout int loads);
      int r, c;
      for (r = 0; r < rows; r++) begin
         for (c = 0; c < cols; c++) begin
            if ((kind == KIND_LOAD_REAL) ? !real_written[r * MAX_DIM + c]
                                         : !cplx_written[r * MAX_DIM + c]) begin
               send_load(kind, r, c, rand_value(), rand_value());
               loads++;
               sender_gap();
            end
         end
      end
   endtask

   // write every store entry the next product will read
   task automatic fill_operands(inout int loads);
      int n, c;
      n = (cur_dim > MAX_DIM) ? MAX_DIM : cur_dim;
      c = (cur_cut > n) ? n : cur_cut;
      if (!cur_order) begin
         fill_store(KIND_LOAD_REAL, n, c, loads);
         fill_store(KIND_LOAD_CPLX, c, n, loads);
      end else begin
         fill_store(KIND_LOAD_REAL, c, n, loads);
         fill_store(KIND_LOAD_CPLX, c, c, loads);
      end
   endtask

   task automatic write_register(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.set_register(index, value);
   endtask

   task automatic write_config(input bit order, input int dim, input int cut);
      write_register(REG_ORDER, CSR_DATA_W'(order));
      write_register(REG_DIMENSION, CSR_DATA_W'(dim));
      write_register(REG_CUTOFF, CSR_DATA_W'(cut));
      cur_order = order;
      cur_dim   = dim;
      cur_cut   = cut;
   endtask

   // drain all outstanding elements, then allow for a start that emits nothing
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic run_phase(input bit order, input int dim, input int cut, input int pct,
                            input int items, input bit hold, input bit drain);
      int sent, starts, roll;
      settle();
      write_config(order, dim, cut);
      idle_pct = pct;
      sent     = 0;
      starts   = 0;
      if (hold) long_hold_pending = 1'b1;
      while (sent < items || starts == 0) begin
         roll = $urandom_range(1, 100);
         if (hold && sent == 0) roll = 10;
         if (roll <= 5) begin
            send_other(KIND_UNUSED);
         end else if (roll <= 17) begin
            fill_operands(sent);
            send_other(KIND_START);
            starts++;
            sent++;
         end else begin
            send_load((roll <= 58) ? KIND_LOAD_REAL : KIND_LOAD_CPLX,
                      $urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                      rand_value(), rand_value());
            sent++;
         end
         sender_gap();
         if (drain && sent == items / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (board.pending() != 0) @(posedge clock);
         end
      end
   endtask

   initial begin : stimulus
      board = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: 2x2 with extreme operands
      write_config(1'b0, 2, 2);
      send_load(KIND_LOAD_REAL, 0, 0, 16'h8000, 16'h0000);
      send_load(KIND_LOAD_REAL, 0, 1, 16'h7fff, 16'hffff);
      send_load(KIND_LOAD_REAL, 1, 0, 16'h0000, 16'h8000);
      send_load(KIND_LOAD_REAL, 1, 1, 16'hffff, 16'h5a5a);
      send_load(KIND_LOAD_REAL, 7, 7, 16'h7fff, 16'h7fff);
      send_load(KIND_LOAD_CPLX, 0, 0, 16'h8000, 16'h8000);
      send_load(KIND_LOAD_CPLX, 0, 1, 16'h7fff, 16'h8000);
      send_load(KIND_LOAD_CPLX, 1, 0, 16'h7fff, 16'h7fff);
      send_load(KIND_LOAD_CPLX, 1, 1, 16'h8000, 16'h0001);
      send_load(KIND_LOAD_CPLX, 7, 7, 16'hffff, 16'hffff);
      send_other(KIND_UNUSED);
      send_other(KIND_START);
      settle();
      write_config(1'b1, 2, 2);
      send_other(KIND_START);
      settle();
      write_config(1'b0, 2, 15);
      send_other(KIND_START);
      settle();
      write_config(1'b0, 2, 0);
      send_other(KIND_START);
      settle();
      write_config(1'b1, 2, 0);
      send_other(KIND_START);
      settle();
      write_config(1'b1, 0, 5);
      send_other(KIND_START);

      // random
      run_phase(1'b0, 8, 8, 30, 12, 1'b0, 1'b0);
      run_phase(1'b1, 8, 8, 20, 12, 1'b1, 1'b0);
      run_phase(1'b0, 15, 15, 0, 12, 1'b0, 1'b1);
      run_phase(1'b1, 5, 3, 40, 12, 1'b0, 1'b0);
      run_phase(1'b0, 3, 0, 20, 12, 1'b0, 1'b0);
      run_phase(1'b1, 12, 15, 30, 12, 1'b0, 1'b0);
      run_phase(1'b0, 7, 4, 0, 12, 1'b0, 1'b0);
      run_phase(1'b1, 8, 1, 20, 12, 1'b0, 1'b0);
      run_phase(1'b0, 1, 1, 40, 12, 1'b0, 1'b0);
      run_phase(1'b1, 6, 6, 20, 12, 1'b0, 1'b0);
      run_phase(1'b0, 11, 9, 30, 12, 1'b0, 1'b0);
      run_phase(1'b1, 8, 8, 0, 20, 1'b0, 1'b0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) begin
         $display("real_complex_matrix_product_tb passed");
      end else begin
         $display("real_complex_matrix_product_tb failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/rcmp_pkg.sv
rtl/core/rcmp_mem.sv
rtl/core/rcmp_seq.sv
rtl/core/rcmp_mac.sv
rtl/core/real_complex_matrix_product.sv
verif/real_complex_matrix_product_tb.sv
